>>> rtl/lps_pkg.sv
`timescale 1ns / 1ps

package lps_pkg;

  // Default coordinate width of the grid.
  localparam int COORD_BITS_DEF = 6;

  // Pixel class codes.
  localparam int CLASS_BITS = 2;
  localparam logic [CLASS_BITS-1:0] CLS_ENDPOINT = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLS_X_STEP   = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLS_Y_ONLY   = 2'd2;
  localparam logic [CLASS_BITS-1:0] CLS_DEFAULT  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } lps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } lps_sts_t;

endpackage

>>> rtl/lps_if.sv
`timescale 1ns / 1ps

// Segment channel: one transaction carries both endpoints.
interface lps_seg_if #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// Pixel channel: one transaction carries one pixel.
interface lps_pix_if #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic signed [COORD_BITS-1:0]       pixel_x;
  logic signed [COORD_BITS-1:0]       pixel_y;
  logic [lps_pkg::CLASS_BITS-1:0]     pixel_class;
  logic                               last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_class, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_class, last_pixel, output ready);
endinterface

>>> rtl/lps_datapath.sv
`timescale 1ns / 1ps

module lps_datapath #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lps_pkg::lps_cmd_t              cmd,
  output lps_pkg::lps_sts_t              sts,
  input  logic signed [COORD_BITS-1:0]   start_x,
  input  logic signed [COORD_BITS-1:0]   start_y,
  input  logic signed [COORD_BITS-1:0]   end_x,
  input  logic signed [COORD_BITS-1:0]   end_y,
  output logic signed [COORD_BITS-1:0]   pixel_x,
  output logic signed [COORD_BITS-1:0]   pixel_y,
  output logic [lps_pkg::CLASS_BITS-1:0] pixel_class,
  output logic                           last_pixel
);

  localparam int EW = COORD_BITS + 2;
  localparam logic [COORD_BITS-1:0] CNT_MAX = {COORD_BITS{1'b1}};

  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0] end_x_r, end_y_r;
  logic [COORD_BITS-1:0]        dx_r, dy_r, dx_in, dy_in;
  logic signed [EW-1:0]         err_r, err_nxt, err_in;
  logic                         neg_x_r, neg_y_r, neg_x_in, neg_y_in;
  logic                         first_r;
  logic [COORD_BITS-1:0]        cnt_r;
  logic signed [COORD_BITS:0]   diff_x, diff_y;
  logic signed [EW:0]           e2;
  logic                         mx, my, at_end;

  // Absolute deltas and step directions of the incoming segment.
  always_comb begin
    diff_x   = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    diff_y   = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    neg_x_in = diff_x[COORD_BITS] || (diff_x == '0);
    neg_y_in = diff_y[COORD_BITS] || (diff_y == '0);
    dx_in    = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    dy_in    = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    err_in   = $signed({2'b00, dx_in}) - $signed({2'b00, dy_in});
  end

  // One Bresenham step from the current pixel.
  always_comb begin
    e2     = {err_r, 1'b0};
    mx     = e2 > -$signed({3'b000, dy_r});
    my     = e2 < $signed({3'b000, dx_r});
    at_end = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);

    err_nxt   = err_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (mx) begin
      err_nxt   = err_nxt - $signed({2'b00, dy_r});
      cur_x_nxt = neg_x_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    end
    if (my) begin
      err_nxt   = err_nxt + $signed({2'b00, dx_r});
      cur_y_nxt = neg_y_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      cnt_r   <= '0;
    end else if (cmd.load) begin
      first_r <= 1'b1;
      cnt_r   <= '0;
    end else if (cmd.step) begin
      first_r <= 1'b0;
      cnt_r   <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      end_x_r <= '0;
      end_y_r <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
      neg_x_r <= 1'b0;
      neg_y_r <= 1'b0;
      err_r   <= '0;
    end else if (cmd.load) begin
      cur_x_r <= start_x;
      cur_y_r <= start_y;
      end_x_r <= end_x;
      end_y_r <= end_y;
      dx_r    <= dx_in;
      dy_r    <= dy_in;
      neg_x_r <= neg_x_in;
      neg_y_r <= neg_y_in;
      err_r   <= err_in;
    end else if (cmd.step) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    if (first_r || at_end) begin
      pixel_class = lps_pkg::CLS_ENDPOINT;
    end else if (mx) begin
      pixel_class = lps_pkg::CLS_X_STEP;
    end else if (my) begin
      pixel_class = lps_pkg::CLS_Y_ONLY;
    end else begin
      pixel_class = lps_pkg::CLS_DEFAULT;
    end
  end

  assign pixel_x    = cur_x_r;
  assign pixel_y    = cur_y_r;
  assign last_pixel = at_end || (cnt_r == CNT_MAX);
  assign sts.last   = last_pixel;

endmodule

>>> rtl/lps_ctrl.sv
`timescale 1ns / 1ps

module lps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lps_pkg::lps_sts_t sts,
  output lps_pkg::lps_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_RUN);
    cmd.load  = in_ready && in_valid;
    cmd.step  = out_valid && out_ready && !sts.last;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (out_ready && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("segment accepted while pixels pending");
  a_load_run: assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> out_valid)
    else $error("no pixel after segment load");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && sts.last |=> in_ready)
    else $error("not idle after last pixel");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && !cmd.load)
    else $error("pixel dropped during stall");

endmodule

>>> rtl/line_pixel_stepper.sv
`timescale 1ns / 1ps

// Bresenham line stepper.
// The in_seg channel takes one segment per transaction: start_x, start_y, end_x
// and end_y, all signed grid coordinates of COORD_BITS bits. The out_pix channel
// returns the pixels of that segment in drawing order, one per transaction,
// with pixel_x, pixel_y, a class code and last_pixel set on the final pixel.
// A segment of P = max(|dx|,|dy|) + 1 pixels is accepted in one transfer;
// its first pixel is offered on the next cycle and, with the receiver always
// ready, one pixel follows per cycle; the next segment is accepted only after
// the last pixel of the segment has been taken.
// The single error-walk step unit advances one pixel per cycle while the
// receiver is ready, and the controller takes one segment at a time.
// When the receiver stalls, the offered pixel and the walk state hold until
// the transaction completes. in_seg.ready is high only while no pixel of a
// segment is pending. A synchronous active-low reset returns the controller
// to idle; any partially emitted segment is dropped.
module line_pixel_stepper #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lps_seg_if.sink       in_seg,
  lps_pix_if.source     out_pix
);

  lps_pkg::lps_cmd_t cmd;
  lps_pkg::lps_sts_t sts;

  // Controller: decides when a segment loads and when the walk steps.
  lps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_seg.valid),
    .in_ready  (in_seg.ready),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: holds the walk registers and forms each pixel.
  lps_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .start_x     (in_seg.start_x),
    .start_y     (in_seg.start_y),
    .end_x       (in_seg.end_x),
    .end_y       (in_seg.end_y),
    .pixel_x     (out_pix.pixel_x),
    .pixel_y     (out_pix.pixel_y),
    .pixel_class (out_pix.pixel_class),
    .last_pixel  (out_pix.last_pixel)
  );

endmodule
